>>> rtl/ttt_pkg.sv
// ----------------------------------------------------------------------------
// ttt_pkg
// Shared types and constants of the tile text typewriter: opcodes, register
// indexes, and the configuration, state, item and result records.
// ----------------------------------------------------------------------------
package ttt_pkg;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_TICK  = 2'd1,
    OP_SKIP  = 2'd2,
    OP_IDLE  = 2'd3
  } opcode_t;

  localparam logic [2:0] REG_BOX_LEFT_COL  = 3'd0;
  localparam logic [2:0] REG_BOX_TOP_ROW   = 3'd1;
  localparam logic [2:0] REG_BOX_WIDTH     = 3'd2;
  localparam logic [2:0] REG_BOX_HEIGHT    = 3'd3;
  localparam logic [2:0] REG_PALETTE_INDEX = 3'd4;
  localparam logic [2:0] REG_CHAR_PERIOD   = 3'd5;
  localparam logic [2:0] REG_INSTANT_MODE  = 3'd6;

  localparam logic [7:0] CH_NEWLINE  = 8'h0A;
  localparam logic [7:0] CH_PRINT_LO = 8'h20;
  localparam logic [7:0] CH_PRINT_HI = 8'h7E;
  localparam logic [7:0] COUNT_MAX   = 8'hFF;
  localparam int         PAL_SHIFT   = 12;

  typedef struct packed {
    logic [4:0] box_left_col;
    logic [4:0] box_top_row;
    logic [5:0] box_width;
    logic [5:0] box_height;
    logic [3:0] palette_index;
    logic [7:0] char_period;
    logic       instant_mode;
  } cfg_t;

  typedef struct packed {
    logic [7:0] col_pos;
    logic [7:0] row_pos;
    logic [7:0] tick_timer;
    logic       running;
    logic       finished;
    logic       skipping;
  } state_t;

  typedef struct packed {
    opcode_t    opcode;
    logic [7:0] char_code;
    logic       char_available;
    logic       char_is_last;
  } item_t;

  typedef struct packed {
    logic        write_enable;
    logic [9:0]  map_index;
    logic [15:0] tile_entry;
    logic        char_taken;
    logic        done_res;
  } result_t;

endpackage

>>> rtl/ttt_step.sv
// ----------------------------------------------------------------------------
// ttt_step
// Combinational next-state and result logic for one transaction: timer,
// cursor advance with wrap, tile entry formation and message completion.
// ----------------------------------------------------------------------------
module ttt_step #(
  parameter int MAP_WIDTH  = 32,
  parameter int MAP_HEIGHT = 32
) (
  input  ttt_pkg::cfg_t    cfg,
  input  ttt_pkg::state_t  st,
  input  ttt_pkg::item_t   item,
  output ttt_pkg::state_t  st_next,
  output ttt_pkg::result_t res
);

  localparam logic [7:0]  MapWidth8  = 8'(MAP_WIDTH);
  localparam logic [7:0]  MapHeight8 = 8'(MAP_HEIGHT);
  localparam logic [15:0] MapWidth16 = 16'(MAP_WIDTH);

  logic [7:0] wrap_col;
  logic [7:0] bottom_row;

  assign wrap_col   = 8'(cfg.box_left_col) + 8'(cfg.box_width);
  assign bottom_row = 8'(cfg.box_top_row) + 8'(cfg.box_height);

  always_comb begin
    ttt_pkg::state_t  s;
    ttt_pkg::result_t r;
    logic             due;
    logic             paced;
    logic [6:0]       tile;
    logic [15:0]      lin;
    logic [7:0]       ch_off;

    s      = st;
    r      = '0;
    due    = 1'b0;
    paced  = 1'b0;
    ch_off = item.char_code - ttt_pkg::CH_PRINT_LO;
    tile   = '0;
    lin    = '0;

    unique case (item.opcode)
      ttt_pkg::OP_START: begin
        s.col_pos    = 8'(cfg.box_left_col);
        s.row_pos    = 8'(cfg.box_top_row);
        s.tick_timer = '0;
        s.running    = 1'b1;
        s.finished   = 1'b0;
        s.skipping   = cfg.instant_mode;
      end
      ttt_pkg::OP_TICK, ttt_pkg::OP_SKIP: begin
        if (st.running && !st.finished) begin
          if (item.opcode == ttt_pkg::OP_SKIP) begin
            s.skipping = 1'b1;
          end
          if (s.skipping) begin
            s.tick_timer = '0;
            due          = 1'b1;
          end else begin
            if (s.tick_timer != ttt_pkg::COUNT_MAX) begin
              s.tick_timer = s.tick_timer + 8'd1;
            end
            if (s.tick_timer >= cfg.char_period) begin
              s.tick_timer = '0;
              due          = 1'b1;
              paced        = 1'b1;
            end
          end
          if (due) begin
            if (item.char_available) begin
              r.char_taken = 1'b1;
              if (item.char_code == ttt_pkg::CH_NEWLINE) begin
                if (s.row_pos != ttt_pkg::COUNT_MAX) begin
                  s.row_pos = s.row_pos + 8'd1;
                end
                s.col_pos = 8'(cfg.box_left_col);
              end else begin
                if (s.row_pos < MapHeight8 && s.col_pos < MapWidth8) begin
                  if (item.char_code >= ttt_pkg::CH_PRINT_LO &&
                      item.char_code <= ttt_pkg::CH_PRINT_HI) begin
                    tile = ch_off[6:0] + 7'd1;
                  end
                  lin            = 16'(s.row_pos) * MapWidth16 + 16'(s.col_pos);
                  r.write_enable = 1'b1;
                  r.map_index    = lin[9:0];
                  r.tile_entry   = 16'(tile) |
                                   (16'(cfg.palette_index) << ttt_pkg::PAL_SHIFT);
                end
                s.col_pos = s.col_pos + 8'd1;
                if (s.col_pos >= wrap_col) begin
                  s.col_pos = 8'(cfg.box_left_col);
                  if (s.row_pos != ttt_pkg::COUNT_MAX) begin
                    s.row_pos = s.row_pos + 8'd1;
                  end
                end
              end
              if ((paced && s.row_pos >= bottom_row) || item.char_is_last) begin
                s.running  = 1'b0;
                s.finished = 1'b1;
                s.skipping = 1'b0;
              end
            end else begin
              // Nothing left to offer: the message ends here.
              s.running  = 1'b0;
              s.finished = 1'b1;
              s.skipping = 1'b0;
            end
          end
        end
      end
      ttt_pkg::OP_IDLE: begin
      end
      default: begin
      end
    endcase

    r.done_res = s.finished || !s.running;
    st_next    = s;
    res        = r;
  end

endmodule

>>> rtl/tile_text_typewriter.sv
// ----------------------------------------------------------------------------
// tile_text_typewriter
// Paced typewriter that reveals message characters into a text tile map.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock cycle while in_stall is low, and
// returns exactly one result for each: the item is captured in an input
// register, and when the output register is free the writer state and the
// result register are updated from a single pass of compare, increment and
// address logic.
// A stalled result holds in the output register while the input register
// still takes one more transaction; in_stall rises only when both are full.
// Register writes take effect on the next item that reaches the result stage.
module tile_text_typewriter #(
  parameter int MAP_WIDTH  = 32,
  parameter int MAP_HEIGHT = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [7:0]  char_code,
  input  logic        char_available,
  input  logic        char_is_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        write_enable,
  output logic [9:0]  map_index,
  output logic [15:0] tile_entry,
  output logic        char_taken,
  output logic        done_res
);

  ttt_pkg::cfg_t    cfg;
  ttt_pkg::state_t  st;
  ttt_pkg::state_t  st_next;
  ttt_pkg::item_t   s1_item;
  ttt_pkg::item_t   in_item;
  ttt_pkg::result_t res_next;
  ttt_pkg::result_t out_res;
  logic             s1_valid;
  logic             out_free;
  logic             advance;
  logic             accept;

  assign in_item.opcode         = ttt_pkg::opcode_t'(opcode);
  assign in_item.char_code      = char_code;
  assign in_item.char_available = char_available;
  assign in_item.char_is_last   = char_is_last;

  assign out_free = !out_valid || !out_stall;
  assign advance  = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;
  assign accept   = in_valid && !in_stall;

  ttt_step #(
    .MAP_WIDTH (MAP_WIDTH),
    .MAP_HEIGHT(MAP_HEIGHT)
  ) u_step (
    .cfg    (cfg),
    .st     (st),
    .item   (s1_item),
    .st_next(st_next),
    .res    (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.box_left_col  <= 5'd2;
      cfg.box_top_row   <= 5'd14;
      cfg.box_width     <= 6'd28;
      cfg.box_height    <= 6'd6;
      cfg.palette_index <= 4'd0;
      cfg.char_period   <= 8'd2;
      cfg.instant_mode  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ttt_pkg::REG_BOX_LEFT_COL:  cfg.box_left_col  <= cfg_data[4:0];
        ttt_pkg::REG_BOX_TOP_ROW:   cfg.box_top_row   <= cfg_data[4:0];
        ttt_pkg::REG_BOX_WIDTH:     cfg.box_width     <= cfg_data[5:0];
        ttt_pkg::REG_BOX_HEIGHT:    cfg.box_height    <= cfg_data[5:0];
        ttt_pkg::REG_PALETTE_INDEX: cfg.palette_index <= cfg_data[3:0];
        ttt_pkg::REG_CHAR_PERIOD:   cfg.char_period   <= cfg_data;
        ttt_pkg::REG_INSTANT_MODE:  cfg.instant_mode  <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      st        <= '0;
    end else begin
      s1_valid <= in_stall ? 1'b1 : in_valid;
      if (out_free) begin
        out_valid <= s1_valid;
      end
      if (advance) begin
        st <= st_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= in_item;
    end
    if (advance) begin
      out_res <= res_next;
    end
  end

  assign write_enable = out_res.write_enable;
  assign map_index    = out_res.map_index;
  assign tile_entry   = out_res.tile_entry;
  assign char_taken   = out_res.char_taken;
  assign done_res     = out_res.done_res;

  // A result without a tile write carries zero address and entry.
  a_no_write_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !write_enable) |-> (map_index == 10'd0 && tile_entry == 16'd0))
    else $error("result without write carries nonzero address or entry");

  // A tile write always consumes the offered character.
  a_write_takes: assert property (@(posedge clk) disable iff (rst)
    (out_valid && write_enable) |-> char_taken)
    else $error("tile written without taking a character");

  // A start transaction arms the writer.
  a_start_arms: assert property (@(posedge clk) disable iff (rst)
    (advance && s1_item.opcode == ttt_pkg::OP_START) |=>
      (st.running && !st.finished && !done_res))
    else $error("start transaction did not arm the writer");

  // The writer is never active and complete at once.
  a_run_xor_done: assert property (@(posedge clk) disable iff (rst)
    !(st.running && st.finished))
    else $error("writer running and finished together");

  // Skip mode only exists while a message is running.
  a_skip_running: assert property (@(posedge clk) disable iff (rst)
    st.skipping |-> st.running)
    else $error("skip mode set without a running message");

endmodule

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the tile text typewriter. Items are driven through
// the valid/stall input channel under several idling patterns, and every
// result is checked field by field against a cycle-free model of the writer
// kept in the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int         MAP_W         = 32;
  localparam int         MAP_H         = 32;
  localparam logic [2:0] REG_UNUSED    = 3'd7;
  localparam int         SETTLE_CYCLES = 4;
  localparam int         DRAIN_LIMIT   = 5000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  opcode = '0;
  logic [7:0]  char_code = '0;
  logic        char_available = 1'b0;
  logic        char_is_last = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        write_enable;
  logic [9:0]  map_index;
  logic [15:0] tile_entry;
  logic        char_taken;
  logic        done_res;

  tile_text_typewriter dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .opcode         (opcode),
    .char_code      (char_code),
    .char_available (char_available),
    .char_is_last   (char_is_last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .write_enable   (write_enable),
    .map_index      (map_index),
    .tile_entry     (tile_entry),
    .char_taken     (char_taken),
    .done_res       (done_res)
  );

  always #5 clk = ~clk;

  // Bench copy of the writer configuration and state.
  logic [4:0] cfg_left   = 5'd2;
  logic [4:0] cfg_top    = 5'd14;
  logic [5:0] cfg_width  = 6'd28;
  logic [5:0] cfg_height = 6'd6;
  logic [3:0] cfg_pal    = 4'd0;
  logic [7:0] cfg_period = 8'd2;
  logic       cfg_instant = 1'b0;

  logic [7:0] cur_col = '0;
  logic [7:0] cur_row = '0;
  logic [7:0] tick_count = '0;
  logic       writer_running = 1'b0;
  logic       writer_finished = 1'b0;
  logic       writer_skipping = 1'b0;

  ttt_pkg::result_t pending_results[$];
  ttt_pkg::result_t last_prediction;
  int               mismatch_count = 0;
  int               sender_idle_pct = 0;
  int               receiver_stall_pct = 0;

  function automatic logic [7:0] row_next(logic [7:0] row);
    return (row < ttt_pkg::COUNT_MAX) ? row + 8'd1 : row;
  endfunction

  function automatic ttt_pkg::result_t typeset_item(ttt_pkg::item_t it);
    ttt_pkg::result_t r;
    logic             due;
    logic             paced;
    logic [7:0]       tile;
    int               idx;
    r = '0;
    due = 1'b0;
    paced = 1'b0;
    if (it.opcode == ttt_pkg::OP_START) begin
      cur_col = {3'b000, cfg_left};
      cur_row = {3'b000, cfg_top};
      tick_count = '0;
      writer_running = 1'b1;
      writer_finished = 1'b0;
      writer_skipping = cfg_instant;
    end else if (it.opcode != ttt_pkg::OP_IDLE && writer_running && !writer_finished) begin
      if (it.opcode == ttt_pkg::OP_SKIP) writer_skipping = 1'b1;
      if (writer_skipping) begin
        tick_count = '0;
        due = 1'b1;
      end else begin
        if (tick_count < ttt_pkg::COUNT_MAX) tick_count = tick_count + 8'd1;
        if (tick_count >= cfg_period) begin
          tick_count = '0;
          due = 1'b1;
          paced = 1'b1;
        end
      end
      if (due) begin
        if (it.char_available) begin
          if (it.char_code == ttt_pkg::CH_NEWLINE) begin
            cur_row = row_next(cur_row);
            cur_col = {3'b000, cfg_left};
          end else begin
            if (int'(cur_row) < MAP_H && int'(cur_col) < MAP_W) begin
              tile = '0;
              if (it.char_code >= ttt_pkg::CH_PRINT_LO &&
                  it.char_code <= ttt_pkg::CH_PRINT_HI)
                tile = it.char_code - ttt_pkg::CH_PRINT_LO + 8'd1;
              idx = int'(cur_row) * MAP_W + int'(cur_col);
              r.write_enable = 1'b1;
              r.map_index = idx[9:0];
              r.tile_entry = {cfg_pal, 4'b0000, tile};
            end
            cur_col = cur_col + 8'd1;
            if (int'(cur_col) >= int'(cfg_left) + int'(cfg_width)) begin
              cur_col = {3'b000, cfg_left};
              cur_row = row_next(cur_row);
            end
          end
          r.char_taken = 1'b1;
        end
        // A missing character, a full box in paced mode, or the final
        // character all close the message.
        if (!it.char_available || it.char_is_last ||
            (paced && int'(cur_row) >= int'(cfg_top) + int'(cfg_height))) begin
          writer_running = 1'b0;
          writer_finished = 1'b1;
          writer_skipping = 1'b0;
        end
      end
    end
    r.done_res = writer_finished || !writer_running;
    return r;
  endfunction

  function automatic ttt_pkg::item_t make_item(ttt_pkg::opcode_t op, logic [7:0] ch,
                                               logic avail, logic last);
    ttt_pkg::item_t it;
    it.opcode = op;
    it.char_code = ch;
    it.char_available = avail;
    it.char_is_last = last;
    return it;
  endfunction

  task automatic report_mismatch(string what, int got, int expected_val);
    $display("%0t mismatch %s: got %0h, expected %0h", $time, what, got, expected_val);
    mismatch_count++;
  endtask

  task automatic set_idling(int send_pct, int recv_pct);
    sender_idle_pct = send_pct;
    receiver_stall_pct = recv_pct;
  endtask

  task automatic send_item(ttt_pkg::item_t it);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    opcode <= it.opcode;
    char_code <= it.char_code;
    char_available <= it.char_available;
    char_is_last <= it.char_is_last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    last_prediction = typeset_item(it);
    pending_results.push_back(last_prediction);
  endtask

  // Lets the pipeline empty before a register write or the end of the run.
  task automatic settle();
    int waited;
    @(negedge clk);
    in_valid <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [7:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      ttt_pkg::REG_BOX_LEFT_COL:  cfg_left = data[4:0];
      ttt_pkg::REG_BOX_TOP_ROW:   cfg_top = data[4:0];
      ttt_pkg::REG_BOX_WIDTH:     cfg_width = data[5:0];
      ttt_pkg::REG_BOX_HEIGHT:    cfg_height = data[5:0];
      ttt_pkg::REG_PALETTE_INDEX: cfg_pal = data[3:0];
      ttt_pkg::REG_CHAR_PERIOD:   cfg_period = data;
      ttt_pkg::REG_INSTANT_MODE:  cfg_instant = data[0];
      default: ;
    endcase
  endtask

  task automatic apply_setup(logic [7:0] left, logic [7:0] top, logic [7:0] width,
                             logic [7:0] height, logic [7:0] pal, logic [7:0] period,
                             logic [7:0] instant);
    write_reg(ttt_pkg::REG_BOX_LEFT_COL, left);
    write_reg(ttt_pkg::REG_BOX_TOP_ROW, top);
    write_reg(ttt_pkg::REG_BOX_WIDTH, width);
    write_reg(ttt_pkg::REG_BOX_HEIGHT, height);
    write_reg(ttt_pkg::REG_PALETTE_INDEX, pal);
    write_reg(ttt_pkg::REG_CHAR_PERIOD, period);
    write_reg(ttt_pkg::REG_INSTANT_MODE, instant);
  endtask

  // Receiver back-pressure.
  always @(negedge clk) begin
    out_stall <= (receiver_stall_pct != 0) && ($urandom_range(99) < receiver_stall_pct);
  end

  always @(posedge clk) begin : result_check
    ttt_pkg::result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", 1, 0);
      end else begin
        want = pending_results.pop_front();
        if (write_enable !== want.write_enable)
          report_mismatch("write_enable", write_enable, want.write_enable);
        if (map_index !== want.map_index)
          report_mismatch("map_index", map_index, want.map_index);
        if (tile_entry !== want.tile_entry)
          report_mismatch("tile_entry", tile_entry, want.tile_entry);
        if (char_taken !== want.char_taken)
          report_mismatch("char_taken", char_taken, want.char_taken);
        if (done_res !== want.done_res)
          report_mismatch("done_res", done_res, want.done_res);
      end
    end
  end

  // Reset values of every register, with the writer idle before the first start.
  task automatic test_reset_defaults();
    send_item(make_item(ttt_pkg::OP_TICK, "A", 1'b1, 1'b0));
    send_item(make_item(ttt_pkg::OP_IDLE, "A", 1'b1, 1'b0));
    send_item(make_item(ttt_pkg::OP_START, "A", 1'b1, 1'b0));
    send_item(make_item(ttt_pkg::OP_TICK, "A", 1'b1, 1'b0));
    send_item(make_item(ttt_pkg::OP_TICK, "A", 1'b1, 1'b0));
    send_item(make_item(ttt_pkg::OP_TICK, "B", 1'b1, 1'b1));
    send_item(make_item(ttt_pkg::OP_TICK, "B", 1'b1, 1'b1));
    settle();
  endtask

  // Printable bounds, control and high bytes, newline, skip and a missing
  // character, with a zero period and the top palette.
  task automatic test_char_classes();
    apply_setup(8'h00, 8'h00, 8'd32, 8'd32, 8'h0F, 8'd0, 8'h00);
    send_item(make_item(ttt_pkg::OP_START, 8'h00, 1'b0, 1'b0));
    send_item(make_item(ttt_pkg::OP_TICK, ttt_pkg::CH_PRINT_LO, 1'b1, 1'b0));
    send_item(make_item(ttt_pkg::OP_TICK, ttt_pkg::CH_PRINT_HI, 1'b1, 1'b0));
    send_item(make_item(ttt_pkg::OP_TICK, 8'h1F, 1'b1, 1'b0));
    send_item(make_item(ttt_pkg::OP_TICK, 8'h7F, 1'b1, 1'b0));
    send_item(make_item(ttt_pkg::OP_TICK, 8'h00, 1'b1, 1'b0));
    send_item(make_item(ttt_pkg::OP_TICK, 8'hFF, 1'b1, 1'b0));
    send_item(make_item(ttt_pkg::OP_TICK, ttt_pkg::CH_NEWLINE, 1'b1, 1'b0));
    send_item(make_item(ttt_pkg::OP_SKIP, "x", 1'b1, 1'b0));
    send_item(make_item(ttt_pkg::OP_TICK, "y", 1'b1, 1'b0));
    send_item(make_item(ttt_pkg::OP_TICK, "z", 1'b0, 1'b0));
    send_item(make_item(ttt_pkg::OP_SKIP, "z", 1'b1, 1'b0));
    settle();
  endtask

  // Last map entry, a cursor past the map edge, and the box filling up.
  task automatic test_box_edges();
    apply_setup(8'd31, 8'd31, 8'd32, 8'd1, 8'h05, 8'd1, 8'h00);
    send_item(make_item(ttt_pkg::OP_START, 8'h00, 1'b1, 1'b0));
    send_item(make_item(ttt_pkg::OP_TICK, "a", 1'b1, 1'b0));
    send_item(make_item(ttt_pkg::OP_TICK, "b", 1'b1, 1'b0));
    send_item(make_item(ttt_pkg::OP_TICK, ttt_pkg::CH_NEWLINE, 1'b1, 1'b0));
    send_item(make_item(ttt_pkg::OP_START, 8'h00, 1'b1, 1'b0));
    send_item(make_item(ttt_pkg::OP_IDLE, "c", 1'b1, 1'b1));
    send_item(make_item(ttt_pkg::OP_TICK, "c", 1'b1, 1'b1));
    settle();
  endtask

  task automatic test_zero_width();
    apply_setup(8'd5, 8'd3, 8'd0, 8'd32, 8'h03, 8'd1, 8'h00);
    send_item(make_item(ttt_pkg::OP_START, 8'h00, 1'b1, 1'b0));
    send_item(make_item(ttt_pkg::OP_TICK, "a", 1'b1, 1'b0));
    send_item(make_item(ttt_pkg::OP_TICK, "b", 1'b1, 1'b0));
    send_item(make_item(ttt_pkg::OP_SKIP, "c", 1'b1, 1'b0));
    send_item(make_item(ttt_pkg::OP_TICK, "d", 1'b1, 1'b1));
    settle();
  endtask

  // Instant mode with a long run of newlines drives the row to its ceiling.
  task automatic test_row_saturation();
    set_idling(19, 19);
    apply_setup(8'd0, 8'd31, 8'd32, 8'd32, 8'h09, 8'd7, 8'h01);
    send_item(make_item(ttt_pkg::OP_START, 8'h00, 1'b1, 1'b0));
    repeat (230) send_item(make_item(ttt_pkg::OP_TICK, ttt_pkg::CH_NEWLINE, 1'b1, 1'b0));
    send_item(make_item(ttt_pkg::OP_TICK, "Z", 1'b1, 1'b0));
    send_item(make_item(ttt_pkg::OP_TICK, "q", 1'b1, 1'b1));
    settle();
  endtask

  task automatic randomize_setup();
    int         roll;
    logic [7:0] left, top, width, height, period;
    roll = $urandom_range(3);
    left = (roll == 0) ? 8'd0 : (roll == 1) ? 8'd31 : 8'($urandom_range(255));
    roll = $urandom_range(3);
    top = (roll == 0) ? 8'd0 : (roll == 1) ? 8'd31 : 8'($urandom_range(255));
    case ($urandom_range(5))
      0: width = 8'd0;
      1: width = 8'd1;
      2: width = 8'd32;
      3: width = 8'd63;
      default: width = 8'($urandom_range(1, 32));
    endcase
    case ($urandom_range(5))
      0: height = 8'd0;
      1: height = 8'd1;
      2: height = 8'd32;
      3: height = 8'd63;
      default: height = 8'($urandom_range(1, 32));
    endcase
    roll = $urandom_range(99);
    if (roll < 70) period = 8'($urandom_range(0, 3));
    else if (roll < 80) period = 8'd255;
    else period = 8'($urandom_range(4, 12));
    apply_setup(left, top, width, height, 8'($urandom_range(255)), period,
                8'($urandom_range(255)));
    write_reg(REG_UNUSED, 8'($urandom_range(255)));
  endtask

  // Well-formed messages with random content, mixed with noise opcodes,
  // restarts, dropped characters and misplaced last flags.
  task automatic test_random_messages();
    int               budget, pos, len, steps, roll;
    logic [7:0]       msg [0:47];
    logic [7:0]       ch;
    logic             avail, last;
    ttt_pkg::opcode_t op;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: set_idling(0, 0);
        1: set_idling(46, 0);
        2: set_idling(0, 46);
        default: set_idling(19, 19);
      endcase
      for (int setup = 0; setup < 3; setup++) begin
        settle();
        randomize_setup();
        budget = 28;
        while (budget > 0) begin
          len = $urandom_range(1, 40);
          for (int i = 0; i < len; i++) begin
            roll = $urandom_range(99);
            if (roll < 10) msg[i] = ttt_pkg::CH_NEWLINE;
            else if (roll < 70)
              msg[i] = 8'($urandom_range(ttt_pkg::CH_PRINT_LO, ttt_pkg::CH_PRINT_HI));
            else msg[i] = 8'($urandom_range(255));
          end
          send_item(make_item(ttt_pkg::OP_START, 8'($urandom_range(255)),
                              1'($urandom_range(1)), 1'($urandom_range(1))));
          budget--;
          pos = 0;
          steps = 0;
          while (budget > 0 && steps < 120 && writer_running && !writer_finished) begin
            roll = $urandom_range(99);
            if (roll < 74) op = ttt_pkg::OP_TICK;
            else if (roll < 88) op = ttt_pkg::OP_SKIP;
            else if (roll < 96) op = ttt_pkg::OP_IDLE;
            else op = ttt_pkg::OP_START;
            ch = (pos < len) ? msg[pos] : 8'($urandom_range(255));
            avail = (pos < len);
            if ($urandom_range(99) < 3) avail = ~avail;
            last = (pos == len - 1);
            if ($urandom_range(99) < 3) last = ~last;
            send_item(make_item(op, ch, avail, last));
            if (last_prediction.char_taken) pos++;
            if (op != ttt_pkg::OP_IDLE) budget--;
            steps++;
          end
          // Now and then send a stray tick or skip after the message loop.
          if ($urandom_range(99) < 20)
            send_item(make_item(ttt_pkg::opcode_t'($urandom_range(1, 2)),
                                8'($urandom_range(255)),
                                1'($urandom_range(1)), 1'($urandom_range(1))));
        end
      end
    end
    set_idling(0, 0);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_char_classes();
    test_box_edges();
    test_zero_width();
    test_row_saturation();
    test_random_messages();
    settle();
    if (pending_results.size() != 0)
      report_mismatch("results never delivered", pending_results.size(), 0);
    if (mismatch_count == 0) begin
      $display("tile_text_typewriter regression: pass");
    end else begin
      $display("tile_text_typewriter regression: fail");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tile_text_typewriter regression: fail");
    $finish;
  end

endmodule
